// File: design/msutf_pkg.sv
// Package with types, codes and constants of the firmware transfer session controller.
package msutf_pkg;

   // Number of session slots and the result budget of one service pass.
   localparam int SESSION_SLOTS = 5;
   localparam int MAX_RESULTS   = 5;
   localparam int SLOT_IDX_W    = (SESSION_SLOTS > 1) ? $clog2(SESSION_SLOTS) : 1;
   localparam int CNT_W         = $clog2(MAX_RESULTS + 1);

   // Register reset values.
   localparam logic [15:0] START_ACK_TIMEOUT_RST  = 16'd6000;
   localparam logic [15:0] DATA_ACK_TIMEOUT_RST   = 16'd200;
   localparam logic [15:0] FINISH_ACK_TIMEOUT_RST = 16'd1000;
   localparam logic [15:0] VERIFY_DELAY_RST       = 16'd10000;
   localparam logic [3:0]  MAX_RESENDS_RST        = 4'd10;
   localparam logic [8:0]  CHUNK_SIZE_RST         = 9'd256;
   localparam logic [8:0]  CHUNK_MAX              = 9'd256;

   // Register indexes of the configuration port.
   localparam logic [2:0] CSR_START_ACK_TIMEOUT  = 3'd0;
   localparam logic [2:0] CSR_DATA_ACK_TIMEOUT   = 3'd1;
   localparam logic [2:0] CSR_FINISH_ACK_TIMEOUT = 3'd2;
   localparam logic [2:0] CSR_VERIFY_DELAY       = 3'd3;
   localparam logic [2:0] CSR_MAX_RESENDS        = 3'd4;
   localparam logic [2:0] CSR_CHUNK_SIZE         = 3'd5;

   // Item modes.
   localparam logic [1:0] MODE_START    = 2'd0;
   localparam logic [1:0] MODE_RESPONSE = 2'd1;
   localparam logic [1:0] MODE_SERVICE  = 2'd2;

   // Client response sub-commands.
   localparam logic [2:0] SUB_START_ACK   = 3'd0;
   localparam logic [2:0] SUB_START_NACK  = 3'd1;
   localparam logic [2:0] SUB_DATA_ACK    = 3'd2;
   localparam logic [2:0] SUB_FINISH_ACK  = 3'd3;
   localparam logic [2:0] SUB_FINISH_NACK = 3'd4;

   // Result event kinds.
   localparam logic [2:0] EV_ACCEPTED    = 3'd0;
   localparam logic [2:0] EV_REJECTED    = 3'd1;
   localparam logic [2:0] EV_SEND_START  = 3'd2;
   localparam logic [2:0] EV_SEND_DATA   = 3'd3;
   localparam logic [2:0] EV_SEND_FINISH = 3'd4;
   localparam logic [2:0] EV_COMPLETED   = 3'd5;
   localparam logic [2:0] EV_FAILED      = 3'd6;

   // Failure sources.
   localparam logic [1:0] FAIL_NONE    = 2'd0;
   localparam logic [1:0] FAIL_CLIENT  = 2'd1;
   localparam logic [1:0] FAIL_TIMEOUT = 2'd2;

   // Session phases.
   typedef enum logic [3:0] {
      PH_IDLE        = 4'd0,
      PH_STARTING    = 4'd1,
      PH_WAIT_START  = 4'd2,
      PH_SENDING     = 4'd3,
      PH_WAIT_DATA   = 4'd4,
      PH_FINISHING   = 4'd5,
      PH_WAIT_FINISH = 4'd6,
      PH_VERIFY      = 4'd7,
      PH_DONE        = 4'd8,
      PH_FAILED      = 4'd9
   } phase_type;

   // One input item.
   typedef struct packed {
      logic [1:0]  mode;
      logic [7:0]  client_address;
      logic [31:0] image_size;
      logic        image_info_valid;
      logic [7:0]  payload_length;
      logic [2:0]  sub_command;
      logic [7:0]  nack_reason;
      logic [31:0] acked_sequence;
      logic [31:0] now_ms;
   } req_type;

   // One result item.
   typedef struct packed {
      logic [2:0]  event_kind;
      logic [2:0]  slot;
      logic [7:0]  client_address_res;
      logic [31:0] sequence_res;
      logic [31:0] byte_offset;
      logic [8:0]  chunk_length;
      logic [1:0]  fail_source;
      logic [7:0]  fail_code;
      logic        last;
   } rsp_type;

   // One session record as kept in the session memory.
   typedef struct packed {
      phase_type   phase;
      logic [7:0]  client;
      logic [31:0] image_size;
      logic [31:0] bytes_sent;
      logic [31:0] sequence_num;
      logic [8:0]  chunk_length;
      logic [3:0]  resends_left;
      logic [31:0] timer_start;
      logic [1:0]  fail_source;
      logic [7:0]  fail_code;
   } session_type;

endpackage

// File: design/multi_session_update_transfer_fsm.sv
// Top level of the firmware transfer session controller.
//
//   channel   ports                        direction  payload
//   request   req_valid/req_ready/req_data in         msutf_pkg::req_type
//   response  rsp_valid/rsp_ready/rsp_data out        msutf_pkg::rsp_type
//   control   csr_we/csr_index/csr_wdata   in         16-bit register write
//
// Each slot visit goes through the single-port session memory in S_READ and
// then S_EXEC (read, then modify and write back). A service item walks the
// slots until the last slot or the result budget, a start or response item
// stops at its first hit, and an ignored item is dropped without a walk.
// Reset clears one valid bit per slot, so every slot reads as idle at once.
// A result waiting in the output register stalls the slot walk only when a
// further result has to move into it.
module multi_session_update_transfer_fsm (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  msutf_pkg::req_type req_data,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output msutf_pkg::rsp_type rsp_data,
   input  logic               csr_we,
   input  logic [2:0]         csr_index,
   input  logic [15:0]        csr_wdata
);
   import msutf_pkg::*;

   typedef enum logic [3:0] {
      S_IDLE  = 4'b0001,
      S_READ  = 4'b0010,
      S_EXEC  = 4'b0100,
      S_FLUSH = 4'b1000
   } state_type;

   // Configuration registers.
   logic [15:0] start_to_ff, data_to_ff, finish_to_ff, verify_ff;
   logic [3:0]  max_resends_ff;
   logic [8:0]  chunk_size_ff;

   // Control and payload registers.
   state_type               state_ff, state_in;
   logic [SLOT_IDX_W-1:0]   idx_ff, idx_in;
   logic [CNT_W-1:0]        cnt_ff, cnt_in;
   req_type                 req_ff, req_in;
   logic                    pend_valid_ff, pend_valid_in;
   rsp_type                 pend_ff, pend_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   rsp_type                 rsp_ff, rsp_in;
   logic [SESSION_SLOTS-1:0] valid_ff, valid_in;
   logic                    rd_valid_ff;

   // Session memory.
   session_type mem [SESSION_SLOTS];
   session_type rd_data_ff;
   logic        mem_re, mem_we;
   session_type mem_wdata;

   // Datapath signals.
   session_type rec;
   session_type start_rec, resp_rec, svc_rec;
   logic        start_hit, resp_hit, svc_emit;
   rsp_type     svc_res, start_res;
   logic [31:0] elapsed, rem, sent_new;
   logic [31:0] limit;
   logic [8:0]  chunk_eff, chunk_sel;
   logic [7:0]  reason;
   logic        out_free, last_slot;
   logic [CNT_W-1:0] cnt_next;

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign last_slot = (idx_ff == SLOT_IDX_W'(SESSION_SLOTS - 1));
   assign cnt_next  = cnt_ff + CNT_W'(1);

   // Configuration writes.
   always_ff @(posedge clock) begin
      if (reset) begin
         start_to_ff    <= START_ACK_TIMEOUT_RST;
         data_to_ff     <= DATA_ACK_TIMEOUT_RST;
         finish_to_ff   <= FINISH_ACK_TIMEOUT_RST;
         verify_ff      <= VERIFY_DELAY_RST;
         max_resends_ff <= MAX_RESENDS_RST;
         chunk_size_ff  <= CHUNK_SIZE_RST;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_START_ACK_TIMEOUT:  start_to_ff    <= csr_wdata;
            CSR_DATA_ACK_TIMEOUT:   data_to_ff     <= csr_wdata;
            CSR_FINISH_ACK_TIMEOUT: finish_to_ff   <= csr_wdata;
            CSR_VERIFY_DELAY:       verify_ff      <= csr_wdata;
            CSR_MAX_RESENDS:        max_resends_ff <= csr_wdata[3:0];
            CSR_CHUNK_SIZE:         chunk_size_ff  <= csr_wdata[8:0];
            default: ;
         endcase
      end
   end

   // Session memory with a registered read port.
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[idx_ff] <= mem_wdata;
      end
      if (mem_re) begin
         rd_data_ff <= mem[idx_ff];
      end
   end

   // A slot that was never written since reset reads as an idle, zero record.
   assign rec = rd_valid_ff ? rd_data_ff : '0;

   // Start: claim the slot if it is idle and the image metadata is good.
   always_comb begin
      start_hit              = req_ff.image_info_valid && (rec.phase == PH_IDLE);
      start_rec              = '0;
      start_rec.client       = req_ff.client_address;
      start_rec.image_size   = req_ff.image_size;
      start_rec.phase        = PH_STARTING;
      start_res                    = '0;
      start_res.client_address_res = req_ff.client_address;
      start_res.last               = 1'b1;
      if (start_hit) begin
         start_res.event_kind = EV_ACCEPTED;
         start_res.slot       = 3'(idx_ff);
      end else begin
         start_res.event_kind = EV_REJECTED;
      end
   end

   // Response: apply an acknowledgement to the first busy slot of the client.
   always_comb begin
      resp_hit = (rec.phase != PH_IDLE) && (rec.client == req_ff.client_address);
      resp_rec = rec;
      reason   = (req_ff.payload_length > 8'd2) ? req_ff.nack_reason : 8'd0;
      sent_new = rec.bytes_sent + 32'(rec.chunk_length);
      case (req_ff.sub_command)
         SUB_START_ACK: begin
            if (rec.phase == PH_WAIT_START) begin
               resp_rec.resends_left = max_resends_ff;
               resp_rec.phase        = PH_SENDING;
            end
         end
         SUB_START_NACK, SUB_FINISH_NACK: begin
            if ((req_ff.sub_command == SUB_START_NACK && rec.phase == PH_WAIT_START) ||
                (req_ff.sub_command == SUB_FINISH_NACK && rec.phase == PH_WAIT_FINISH)) begin
               resp_rec.fail_source = FAIL_CLIENT;
               resp_rec.fail_code   = reason;
               resp_rec.phase       = PH_FAILED;
            end
         end
         SUB_DATA_ACK: begin
            if (rec.phase == PH_WAIT_DATA && req_ff.acked_sequence == rec.sequence_num) begin
               resp_rec.bytes_sent   = sent_new;
               resp_rec.sequence_num = rec.sequence_num + 32'd1;
               resp_rec.resends_left = max_resends_ff;
               resp_rec.phase = (sent_new >= rec.image_size) ? PH_FINISHING : PH_SENDING;
            end
         end
         SUB_FINISH_ACK: begin
            if (rec.phase == PH_WAIT_FINISH) begin
               resp_rec.phase       = PH_VERIFY;
               resp_rec.timer_start = req_ff.now_ms;
            end
         end
         default: ;
      endcase
   end

   // Service: advance one slot and form its result, if it has one.
   always_comb begin
      elapsed   = req_ff.now_ms - rec.timer_start;
      rem       = rec.image_size - rec.bytes_sent;
      if (chunk_size_ff == 9'd0) begin
         chunk_eff = 9'd1;
      end else if (chunk_size_ff > CHUNK_MAX) begin
         chunk_eff = CHUNK_MAX;
      end else begin
         chunk_eff = chunk_size_ff;
      end
      chunk_sel = (rem < 32'(chunk_eff)) ? rem[8:0] : chunk_eff;
      case (rec.phase)
         PH_WAIT_START: limit = 32'(start_to_ff);
         PH_WAIT_DATA:  limit = 32'(data_to_ff);
         PH_WAIT_FINISH: limit = 32'(finish_to_ff);
         default:       limit = 32'(verify_ff);
      endcase
      svc_rec  = rec;
      svc_emit = 1'b0;
      svc_res                    = '0;
      svc_res.slot               = 3'(idx_ff);
      svc_res.client_address_res = rec.client;
      case (rec.phase)
         PH_DONE: begin
            svc_emit           = 1'b1;
            svc_res.event_kind = EV_COMPLETED;
            svc_rec            = '0;
         end
         PH_FAILED: begin
            svc_emit            = 1'b1;
            svc_res.event_kind  = EV_FAILED;
            svc_res.fail_source = rec.fail_source;
            svc_res.fail_code   = rec.fail_code;
            svc_rec             = '0;
         end
         PH_STARTING: begin
            svc_emit            = 1'b1;
            svc_res.event_kind  = EV_SEND_START;
            svc_rec.timer_start = req_ff.now_ms;
            svc_rec.phase       = PH_WAIT_START;
         end
         PH_SENDING: begin
            svc_emit             = 1'b1;
            svc_res.event_kind   = EV_SEND_DATA;
            svc_res.sequence_res = rec.sequence_num;
            svc_res.byte_offset  = rec.bytes_sent;
            svc_res.chunk_length = chunk_sel;
            svc_rec.chunk_length = chunk_sel;
            svc_rec.timer_start  = req_ff.now_ms;
            svc_rec.phase        = PH_WAIT_DATA;
         end
         PH_FINISHING: begin
            svc_emit            = 1'b1;
            svc_res.event_kind  = EV_SEND_FINISH;
            svc_rec.timer_start = req_ff.now_ms;
            svc_rec.phase       = PH_WAIT_FINISH;
         end
         PH_WAIT_START, PH_WAIT_DATA, PH_WAIT_FINISH: begin
            if (elapsed > limit) begin
               if (rec.phase == PH_WAIT_DATA && rec.resends_left != 4'd0) begin
                  svc_rec.resends_left = rec.resends_left - 4'd1;
                  svc_rec.phase        = PH_SENDING;
               end else begin
                  svc_rec.fail_source = FAIL_TIMEOUT;
                  svc_rec.fail_code   = 8'd0;
                  svc_rec.phase       = PH_FAILED;
               end
            end
         end
         PH_VERIFY: begin
            if (elapsed > limit) begin
               svc_rec.phase = PH_DONE;
            end
         end
         default: ;
      endcase
   end

   // Sequencer: walks the slots for the item held in req_ff.
   always_comb begin
      state_in      = state_ff;
      idx_in        = idx_ff;
      cnt_in        = cnt_ff;
      req_in        = req_ff;
      pend_valid_in = pend_valid_ff;
      pend_in       = pend_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_in        = rsp_ff;
      valid_in      = valid_ff;
      mem_re        = 1'b0;
      mem_we        = 1'b0;
      mem_wdata     = rec;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               req_in = req_data;
               idx_in = '0;
               cnt_in = '0;
               if (req_data.mode == MODE_START || req_data.mode == MODE_SERVICE ||
                   (req_data.mode == MODE_RESPONSE && req_data.payload_length >= 8'd2)) begin
                  state_in = S_READ;
               end
            end
         end
         S_READ: begin
            mem_re   = 1'b1;
            state_in = S_EXEC;
         end
         S_EXEC: begin
            case (req_ff.mode)
               MODE_START: begin
                  if (start_hit || last_slot) begin
                     if (out_free) begin
                        rsp_valid_in = 1'b1;
                        rsp_in       = start_res;
                        state_in     = S_IDLE;
                        if (start_hit) begin
                           mem_we           = 1'b1;
                           mem_wdata        = start_rec;
                           valid_in[idx_ff] = 1'b1;
                        end
                     end
                  end else begin
                     idx_in   = idx_ff + SLOT_IDX_W'(1);
                     state_in = S_READ;
                  end
               end
               MODE_RESPONSE: begin
                  if (resp_hit) begin
                     mem_we           = 1'b1;
                     mem_wdata        = resp_rec;
                     valid_in[idx_ff] = 1'b1;
                     state_in         = S_IDLE;
                  end else if (last_slot) begin
                     state_in = S_IDLE;
                  end else begin
                     idx_in   = idx_ff + SLOT_IDX_W'(1);
                     state_in = S_READ;
                  end
               end
               default: begin
                  // Service walk; a new result pushes the held one out first.
                  if (!(svc_emit && pend_valid_ff && !out_free)) begin
                     mem_we           = 1'b1;
                     mem_wdata        = svc_rec;
                     valid_in[idx_ff] = 1'b1;
                     if (svc_emit) begin
                        if (pend_valid_ff) begin
                           rsp_valid_in = 1'b1;
                           rsp_in       = pend_ff;
                        end
                        pend_valid_in = 1'b1;
                        pend_in       = svc_res;
                        cnt_in        = cnt_next;
                     end
                     if (last_slot || (svc_emit && cnt_next == CNT_W'(MAX_RESULTS))) begin
                        state_in = S_FLUSH;
                     end else begin
                        idx_in   = idx_ff + SLOT_IDX_W'(1);
                        state_in = S_READ;
                     end
                  end
               end
            endcase
         end
         S_FLUSH: begin
            if (!pend_valid_ff) begin
               state_in = S_IDLE;
            end else if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_in        = pend_ff;
               rsp_in.last   = 1'b1;
               pend_valid_in = 1'b0;
               state_in      = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         idx_ff        <= '0;
         cnt_ff        <= '0;
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         valid_ff      <= '0;
         rd_valid_ff   <= 1'b0;
      end else begin
         state_ff      <= state_in;
         idx_ff        <= idx_in;
         cnt_ff        <= cnt_in;
         pend_valid_ff <= pend_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
         valid_ff      <= valid_in;
         if (mem_re) begin
            rd_valid_ff <= valid_ff[idx_ff];
         end
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      req_ff  <= req_in;
      pend_ff <= pend_in;
      rsp_ff  <= rsp_in;
   end

endmodule

// File: design/msutf_checker.sv
// Port checker for the firmware transfer session controller and its bind.
module msutf_checker (
   input logic               clock,
   input logic               reset,
   input logic               req_valid,
   input logic               req_ready,
   input msutf_pkg::req_type req_data,
   input logic               rsp_valid,
   input logic               rsp_ready,
   input msutf_pkg::rsp_type rsp_data,
   input logic               csr_we,
   input logic [2:0]         csr_index,
   input logic [15:0]        csr_wdata
);
   import msutf_pkg::*;

   // A stalled result item holds.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("result item changed while stalled");

   // Start items give exactly one result, so it is the last one.
   a_start_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_data.event_kind == EV_ACCEPTED ||
                    rsp_data.event_kind == EV_REJECTED) |-> rsp_data.last)
      else $error("start result without last flag");

   // Failure fields are zero except on a failed event.
   a_fail_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.event_kind != EV_FAILED |->
         rsp_data.fail_source == FAIL_NONE && rsp_data.fail_code == 8'd0)
      else $error("failure fields set on a non-failure event");

   // Chunk fields are zero except on a send data event.
   a_chunk_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.event_kind != EV_SEND_DATA |->
         rsp_data.sequence_res == 32'd0 && rsp_data.byte_offset == 32'd0 &&
         rsp_data.chunk_length == 9'd0)
      else $error("chunk fields set on a non-data event");

endmodule

bind multi_session_update_transfer_fsm msutf_checker u_msutf_checker (.*);
